// ===== design/clgm_pkg.sv =====
`default_nettype none
package clgm_pkg;
    localparam int SIDE_DEFAULT = 32;
    localparam int COORD_W = 5;
    localparam int RAND_W = 32;
    localparam int DE_W = 20;
    localparam int COUNT_W = 16;
    localparam int REG_W = 16;
    localparam int INDEX_W = 3;

    localparam logic [INDEX_W-1:0] REG_POTENTIAL = 3'd0;
    localparam logic [INDEX_W-1:0] REG_COUPLING_X = 3'd1;
    localparam logic [INDEX_W-1:0] REG_COUPLING_Y = 3'd2;
    localparam logic [INDEX_W-1:0] REG_COUPLING_Z = 3'd3;
    localparam logic [INDEX_W-1:0] REG_BETA = 3'd4;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [31:0] STEP_DOWN = 32'd4283353945;
    localparam logic [15:0] BETA_ZERO_TEMP = 16'hFFFF;
    localparam logic signed [DE_W-1:0] DE_MAX = 20'sd524287;
    localparam logic signed [DE_W-1:0] DE_MIN = -20'sd524288;

    // 2^32 * 2^(-i/256), built by the same rounded recurrence
    function automatic logic [32:0] frac_entry(input int idx);
        logic [32:0] f;
        logic [64:0] p;
        f = 33'h1_0000_0000;
        for (int k = 0; k < idx; k++)
        begin
            p = 65'(f) * 65'(STEP_DOWN) + 65'h8000_0000;
            f = p[64:32];
        end
        return f;
    endfunction

    typedef struct packed {
        logic signed [15:0] potential;
        logic signed [15:0] coupling_x;
        logic signed [15:0] coupling_y;
        logic signed [15:0] coupling_z;
        logic [15:0]        beta;
    } cfg_t;
endpackage
`default_nettype wire

// ===== design/clgm_if.sv =====
`default_nettype none
interface clgm_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] site_x;
    logic [4:0] site_y;
    logic [4:0] site_z;
    logic [31:0] random_fraction;
    modport source (output valid, site_x, site_y, site_z, random_fraction, input ready);
    modport sink (input valid, site_x, site_y, site_z, random_fraction, output ready);
endinterface

interface clgm_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        blocked;
    logic        site_now;
    logic [19:0] energy_change;
    logic [15:0] occupied_total;
    modport source (output valid, accepted, blocked, site_now, energy_change, occupied_total,
                    input ready);
    modport sink (input valid, accepted, blocked, site_now, energy_change, occupied_total,
                  output ready);
endinterface

interface clgm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/clgm_ram.sv =====
`default_nettype none
module clgm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/clgm_threshold.sv =====
`default_nettype none
// sequential exp threshold: multiply by beta, multiply by log2(e), table, shift
module clgm_threshold (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [18:0] de,
    input  wire logic [15:0] beta,
    output logic             done,
    output logic [32:0]      threshold
);
    typedef enum logic [2:0] {T_IDLE, T_MUL1, T_MUL2, T_MUL3, T_LOOK, T_DONE} tstate_t;

    tstate_t      state_reg;
    logic [34:0]  x_reg;
    logic [51:0]  y_reg;
    logic [32:0]  f_reg;
    logic [32:0]  thr_reg;

    logic [51:0] prod_lo;
    logic [35:0] y_full;
    logic [19:0] n_val;
    logic [7:0]  i_val;
    logic [32:0] frac_rom [256];

    assign y_full = y_reg[51:16];
    assign n_val  = y_full[35:16];
    assign i_val  = y_full[15:8];

    // constant fraction table
    for (genvar g = 0; g < 256; g++)
    begin : g_frac
        assign frac_rom[g] = clgm_pkg::frac_entry(g);
    end

    // log2(e) product split in two partials, 18 x 17 and 17 x 17 bits
    always_comb
    begin
        prod_lo = 52'(x_reg[17:0]) * 52'(clgm_pkg::LOG2E_Q16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
        end
        else
        begin
            unique case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= 35'(de) * 35'(beta);
                        state_reg <= T_MUL1;
                    end
                end
                T_MUL1:
                begin
                    y_reg     <= prod_lo;
                    state_reg <= T_MUL2;
                end
                T_MUL2:
                begin
                    y_reg     <= y_reg + ((52'(x_reg[34:18]) * 52'(clgm_pkg::LOG2E_Q16)) << 18);
                    state_reg <= T_MUL3;
                end
                T_MUL3:
                begin
                    f_reg     <= frac_rom[i_val];
                    state_reg <= T_LOOK;
                end
                T_LOOK:
                begin
                    if (n_val >= 20'd40)
                    begin
                        thr_reg <= '0;
                    end
                    else
                    begin
                        thr_reg <= f_reg >> n_val[5:0];
                    end
                    state_reg <= T_DONE;
                end
                T_DONE:
                begin
                    state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign done      = (state_reg == T_DONE);
    assign threshold = thr_reg;
endmodule
`default_nettype wire

// ===== design/constrained_lattice_gas_metropolis_unit.sv =====
`default_nettype none
// channel     dir   payload
// in_ch       in    site_x, site_y, site_z, random_fraction
// out_ch      out   accepted, blocked, site_now, energy_change, occupied_total
// cfg_ch      in    index, data
// one move passes through acceptance, seven serial lattice reads, a wait to settle the
// last read, a decision, the threshold unit's MUL1, MUL2, MUL3, LOOK and DONE states
// (only when a threshold is needed), one write back and a result state
// after reset a clearing pass walks the lattice one site a cycle
// no move is taken during it; a waiting result holds until out_ch.ready
module constrained_lattice_gas_metropolis_unit #(
    parameter int SIDE = clgm_pkg::SIDE_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    clgm_in_if.sink   in_ch,
    clgm_out_if.source out_ch,
    clgm_cfg_if.sink  cfg_ch
);
    localparam int CW = $clog2(SIDE);
    localparam int SITES = SIDE * SIDE * SIDE;
    localparam int AW = $clog2(SITES);

    typedef enum logic [3:0] {S_CLEAR, S_IDLE, S_READ, S_WAIT, S_CALC, S_THR, S_WRITE, S_OUT}
        state_t;

    state_t state_reg;
    clgm_pkg::cfg_t cfg_reg;
    logic [AW-1:0] clr_reg;
    logic [CW-1:0] x_reg, y_reg, z_reg;
    logic [31:0]   rnd_reg;
    logic [2:0]    rd_reg;
    logic [2:0]    cap_reg;
    logic          cap_valid_reg;
    logic          was_reg, partner_reg;
    logic [1:0]    nx_reg, ny_reg, nz_reg;
    logic signed [19:0] de_reg;
    logic          acc_reg, blk_reg, now_reg;
    logic [15:0]   count_reg;
    logic          thr_start;
    logic          thr_done;
    logic [32:0]   thr_val;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic          ram_wdata, ram_rdata;

    logic [CW-1:0] rx, ry, rz, zm, zp, partner;
    logic signed [21:0] sum;
    logic signed [21:0] de_full;
    logic [CW-1:0] coord_mod [32];

    // coordinate reduced modulo SIDE
    for (genvar g = 0; g < 32; g++)
    begin : g_coord
        assign coord_mod[g] = CW'(g % SIDE);
    end

    function automatic logic [CW-1:0] wrap_dec(input logic [CW-1:0] v);
        return (v == '0) ? CW'(SIDE - 1) : v - 1'b1;
    endfunction
    function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] v);
        return (v == CW'(SIDE - 1)) ? '0 : v + 1'b1;
    endfunction

    always_comb
    begin
        zm = wrap_dec(z_reg);
        zp = wrap_inc(z_reg);
        partner = z_reg[0] ? zm : zp;
        rx = x_reg;
        ry = y_reg;
        rz = z_reg;
        case (rd_reg)
            3'd1: rx = wrap_dec(x_reg);
            3'd2: rx = wrap_inc(x_reg);
            3'd3: ry = wrap_dec(y_reg);
            3'd4: ry = wrap_inc(y_reg);
            3'd5: rz = zm;
            3'd6: rz = zp;
            default: rx = x_reg;
        endcase
        ram_raddr = AW'((32'(rx) * SIDE + 32'(ry)) * SIDE + 32'(rz));
    end

    always_comb
    begin
        sum = 22'(cfg_reg.potential)
            + 22'(cfg_reg.coupling_x) * $signed({20'd0, nx_reg})
            + 22'(cfg_reg.coupling_y) * $signed({20'd0, ny_reg})
            + 22'(cfg_reg.coupling_z) * $signed({20'd0, nz_reg});
        de_full = was_reg ? sum : -sum;
    end

    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE && acc_reg);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg
                       : AW'((32'(x_reg) * SIDE + 32'(y_reg)) * SIDE + 32'(z_reg));
    assign ram_wdata = (state_reg == S_CLEAR) ? 1'b0 : !was_reg;
    assign thr_start = (state_reg == S_CALC) && !blk_reg && (de_reg > 0)
                       && (cfg_reg.beta != clgm_pkg::BETA_ZERO_TEMP);

    clgm_ram #(.WIDTH(1), .DEPTH(SITES)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    clgm_threshold u_thr (
        .clk(clk), .rst_n(rst_n), .start(thr_start), .de(de_reg[18:0]),
        .beta(cfg_reg.beta), .done(thr_done), .threshold(thr_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            cfg_reg   <= '{16'sd0, 16'sd256, 16'sd256, 16'sd256, 16'd256};
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                unique case (cfg_ch.index)
                    clgm_pkg::REG_POTENTIAL:  cfg_reg.potential  <= cfg_ch.data;
                    clgm_pkg::REG_COUPLING_X: cfg_reg.coupling_x <= cfg_ch.data;
                    clgm_pkg::REG_COUPLING_Y: cfg_reg.coupling_y <= cfg_ch.data;
                    clgm_pkg::REG_COUPLING_Z: cfg_reg.coupling_z <= cfg_ch.data;
                    clgm_pkg::REG_BETA:       cfg_reg.beta       <= cfg_ch.data;
                    default: ;
                endcase
            end
            cap_valid_reg <= (state_reg == S_READ);
            cap_reg <= rd_reg;
            if (cap_valid_reg)
            begin
                case (cap_reg)
                    3'd0: was_reg <= ram_rdata;
                    3'd1: nx_reg <= {1'b0, ram_rdata};
                    3'd2: nx_reg <= nx_reg + {1'b0, ram_rdata};
                    3'd3: ny_reg <= {1'b0, ram_rdata};
                    3'd4: ny_reg <= ny_reg + {1'b0, ram_rdata};
                    3'd5:
                    begin
                        nz_reg <= {1'b0, ram_rdata};
                        if (zm == partner) partner_reg <= ram_rdata;
                    end
                    3'd6:
                    begin
                        nz_reg <= nz_reg + {1'b0, ram_rdata};
                        if (zp == partner) partner_reg <= ram_rdata;
                    end
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(SITES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        x_reg   <= coord_mod[in_ch.site_x];
                        y_reg   <= coord_mod[in_ch.site_y];
                        z_reg   <= coord_mod[in_ch.site_z];
                        rnd_reg <= in_ch.random_fraction;
                        rd_reg  <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    rd_reg <= rd_reg + 1'b1;
                    if (rd_reg == 3'd6) state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!cap_valid_reg) state_reg <= S_CALC;
                    if (de_full > 22'(clgm_pkg::DE_MAX)) de_reg <= clgm_pkg::DE_MAX;
                    else if (de_full < 22'(clgm_pkg::DE_MIN)) de_reg <= clgm_pkg::DE_MIN;
                    else de_reg <= de_full[19:0];
                    blk_reg <= !was_reg && partner_reg;
                end
                S_CALC:
                begin
                    if (blk_reg)
                    begin
                        acc_reg <= 1'b0;
                        state_reg <= S_WRITE;
                    end
                    else if (de_reg <= 0)
                    begin
                        acc_reg <= 1'b1;
                        state_reg <= S_WRITE;
                    end
                    else if (cfg_reg.beta == clgm_pkg::BETA_ZERO_TEMP)
                    begin
                        acc_reg <= (rnd_reg == '0);
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        state_reg <= S_THR;
                    end
                end
                S_THR:
                begin
                    if (thr_done)
                    begin
                        acc_reg <= {1'b0, rnd_reg} <= thr_val;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    now_reg <= acc_reg ? !was_reg : was_reg;
                    if (acc_reg) count_reg <= was_reg ? count_reg - 1'b1 : count_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.accepted = acc_reg;
    assign out_ch.blocked  = blk_reg;
    assign out_ch.site_now = now_reg;
    assign out_ch.energy_change  = de_reg;
    assign out_ch.occupied_total = count_reg;
endmodule
`default_nettype wire
